// File: rtl/hfs_pkg.sv
package hfs_pkg;

   localparam int MAX_HOLES = 16;
   localparam int IDX_W     = $clog2(MAX_HOLES);
   localparam int CNT_W     = $clog2(MAX_HOLES + 1);
   localparam int SIZE_W    = 16;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_REVERSED = 2'd2;
   localparam logic [1:0] ST_NOFIT    = 2'd3;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              valid;
      logic [1:0]        mode;
      logic [SIZE_W-1:0] request;
      logic [IDX_W-1:0]  index;
   } hfs_pick_ctl_type;

   function automatic logic [3:0] port_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage

// File: rtl/hole_fit_selector_core.sv
// an append goes from S_IDLE through S_DONE to the response register; a query passes
// S_IDLE, S_SCAN and S_DONE, and S_DONE waits while an earlier response is still held
// one request at a time: req_ready is high only in S_IDLE, reached again once the
// response is loaded; a query reads the hole table one entry per cycle through its
// single read port
// reset clears the hole count, the fit mode, the state and the valid flags; table contents stay undefined
module hole_fit_selector_core
   import hfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [15:0]       req_hole_start,
   input  logic [15:0]       req_hole_end,
   input  logic [15:0]       req_request_size,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_hole_index,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [SIZE_W-1:0] req_size_ff, req_size_in;
   logic              is_query_ff, is_query_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_index_ff, rsp_index_in;

   logic              accept;
   logic              full;
   logic              reversed;
   logic              wr_en;
   logic              rd_en;
   logic [SIZE_W-1:0] rd_data;
   logic              found;
   logic [IDX_W-1:0]  best_index;
   hfs_pick_ctl_type  pick_ctl;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == CNT_W'(MAX_HOLES);
   assign reversed  = req_hole_end < req_hole_start;
   assign wr_en     = accept && req_cmd == CMD_APPEND && !full && !reversed;
   assign rd_en     = state_ff == S_SCAN && issue_ff < count_ff;

   always_comb begin
      pick_ctl.clear   = accept;
      pick_ctl.valid   = cmp_valid_ff;
      pick_ctl.mode    = mode_ff;
      pick_ctl.request = req_size_ff;
      pick_ctl.index   = cmp_idx_ff;
   end

   hfs_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_hole_end - req_hole_start),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   hfs_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pick_ctl),
      .size       (rd_data),
      .found      (found),
      .best_index (best_index)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      req_size_in   = req_size_ff;
      is_query_in   = is_query_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               is_query_in = req_cmd == CMD_QUERY;
               req_size_in = req_request_size;
               issue_in    = '0;
               res_idx_in  = '0;
               if (req_cmd == CMD_QUERY) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else if (reversed) begin
                     res_status_in = ST_REVERSED;
                  end else begin
                     res_status_in = ST_OK;
                     res_idx_in    = count_ff[IDX_W-1:0];
                     count_in      = count_ff + 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[IDX_W-1:0];
            end else if (!cmp_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (is_query_ff) begin
                  rsp_status_in = found ? ST_OK : ST_NOFIT;
                  rsp_index_in  = found ? port_index(best_index) : 4'd0;
               end else begin
                  rsp_status_in = res_status_ff;
                  rsp_index_in  = port_index(res_idx_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= FIT_FIRST;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      req_size_ff   <= req_size_in;
      is_query_ff   <= is_query_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_hole_index = rsp_index_ff;

endmodule

// File: rtl/hfs_table.sv
module hfs_table
   import hfs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [SIZE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [SIZE_W-1:0] rd_data
);

   logic [SIZE_W-1:0] mem_ff [MAX_HOLES];
   logic [SIZE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hfs_pick.sv
module hfs_pick
   import hfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hfs_pick_ctl_type  ctl,
   input  logic [SIZE_W-1:0] size,
   output logic              found,
   output logic [IDX_W-1:0]  best_index
);

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic              fits;
   logic              take;

   always_comb begin
      fits = size > ctl.request;
      take = 1'b0;
      if (ctl.valid && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (ctl.mode == FIT_BEST) begin
            take = size < best_size_ff;
         end else if (ctl.mode == FIT_WORST) begin
            take = size > best_size_ff;
         end
      end
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in     = 1'b1;
         best_idx_in  = ctl.index;
         best_size_in = size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   assign found      = found_ff;
   assign best_index = best_idx_ff;

endmodule

// File: bench/hole_fit_selector_core_test.sv
`timescale 1ns / 100ps

module hole_fit_selector_core_test;
   import hfs_pkg::*;

   localparam logic [1:0] FIT_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned POOL_SIZE = 8;
   localparam int unsigned PHASES = 9;
   localparam int unsigned PHASE_ITEMS = 160;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] index;
   } fit_answer_type;

   class hole_fit_scoreboard;
      logic [15:0] size_table [MAX_HOLES];
      int unsigned hole_total = 0;
      logic [1:0] fit_mode = FIT_FIRST;
      fit_answer_type awaited [$];
      int unsigned failures = 0;

      function void note_request(logic cmd, logic [15:0] start_addr, logic [15:0] end_addr,
                                 logic [15:0] req_size);
         fit_answer_type ans;
         bit found;
         int unsigned i;
         int unsigned pick;
         int unsigned surplus;
         int unsigned chosen_surplus;
         ans.status = ST_OK;
         ans.index = 4'd0;
         if (cmd == CMD_APPEND) begin
            if (hole_total >= MAX_HOLES) begin
               ans.status = ST_FULL;
            end else if (end_addr < start_addr) begin
               ans.status = ST_REVERSED;
            end else begin
               size_table[hole_total] = end_addr - start_addr;
               ans.index = 4'(hole_total);
               hole_total++;
            end
         end else begin
            found = 1'b0;
            pick = 0;
            chosen_surplus = 0;
            for (i = 0; i < hole_total; i++) begin
               if (size_table[i] > req_size) begin
                  surplus = size_table[i] - req_size;
                  if (!found) begin
                     found = 1'b1;
                     pick = i;
                     chosen_surplus = surplus;
                  end else if (fit_mode == FIT_BEST && surplus < chosen_surplus) begin
                     pick = i;
                     chosen_surplus = surplus;
                  end else if (fit_mode == FIT_WORST && surplus > chosen_surplus) begin
                     pick = i;
                     chosen_surplus = surplus;
                  end
               end
            end
            if (found) begin
               ans.index = 4'(pick);
            end else begin
               ans.status = ST_NOFIT;
            end
         end
         awaited.push_back(ans);
      endfunction

      function void check_response(logic [1:0] status, logic [3:0] index);
         fit_answer_type want;
         if (awaited.size() == 0) begin
            $error("unexpected response: status %0d, hole_index %0d", status, index);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (index !== want.index) begin
            $error("hole_index: expected %0d, actual %0d", want.index, index);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_APPEND;
   logic [15:0] req_hole_start = 16'd0;
   logic [15:0] req_hole_end = 16'd0;
   logic [15:0] req_request_size = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_hole_index;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = FIT_FIRST;

   hole_fit_scoreboard board = new;
   bit gaps_on = 1'b1;
   bit long_hold = 1'b0;
   int unsigned cycles_run = 0;
   int unsigned size_pool [POOL_SIZE];

   hole_fit_selector_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_hole_start   (req_hole_start),
      .req_hole_end     (req_hole_end),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_hole_index   (rsp_hole_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_response(rsp_status, rsp_hole_index);
         end
         if (req_valid && req_ready) begin
            board.note_request(req_cmd, req_hole_start, req_hole_end, req_request_size);
         end
      end
   end

   // receiver: short random stalls, plus one long hold-off on demand
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic offer_request(logic cmd, logic [15:0] start_addr, logic [15:0] end_addr,
                                logic [15:0] req_size);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_hole_start <= start_addr;
      req_hole_end <= end_addr;
      req_request_size <= req_size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic set_fit_mode(logic [1:0] mode);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.fit_mode = mode;
   endtask

   task automatic random_request();
      int unsigned roll;
      int unsigned hole_len;
      logic [15:0] base;
      logic [15:0] want;
      roll = $urandom_range(0, 99);
      hole_len = size_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 8) begin
         base = 16'($urandom_range(0, 65535 - hole_len));
         offer_request(CMD_APPEND, base, base + 16'(hole_len), 16'($urandom));
      end else if (roll < 14) begin
         offer_request(CMD_APPEND, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: want = 16'(hole_len);
            1: want = (hole_len == 0) ? 16'd0 : 16'(hole_len - 1);
            2: want = 16'($urandom_range(0, 255));
            default: want = 16'($urandom);
         endcase
         offer_request(CMD_QUERY, 16'($urandom), 16'($urandom), want);
      end
   endtask

   initial begin
      logic [1:0] phase_modes [PHASES];
      int unsigned p;
      int unsigned n;
      phase_modes = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_SPARE, FIT_WORST,
                      FIT_BEST, FIT_FIRST, FIT_WORST, FIT_BEST};
      size_pool[0] = 200;
      size_pool[1] = 1;
      size_pool[2] = 0;
      for (p = 3; p < POOL_SIZE; p++) begin
         size_pool[p] = (p < 6) ? $urandom_range(2, 600) : $urandom_range(0, 65535);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_fit_mode(FIT_FIRST);

      // empty table, reversed, zero-size and full-range holes, ties
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'd0);
      offer_request(CMD_APPEND, 16'd5, 16'd4, 16'd0);
      offer_request(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_request(CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'd0);
      offer_request(CMD_APPEND, 16'd0, 16'hFFFF, 16'd0);
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'hFFFF);
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'hFFFE);
      offer_request(CMD_APPEND, 16'd100, 16'd300, 16'd0);
      offer_request(CMD_APPEND, 16'd1000, 16'd1200, 16'd0);
      offer_request(CMD_APPEND, 16'd0, 16'd1, 16'd0);
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'd0);
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'd199);
      offer_request(CMD_QUERY, 16'd0, 16'd0, 16'd200);
      offer_request(CMD_APPEND, 16'hFFFF, 16'd0, 16'd0);
      offer_request(CMD_APPEND, 16'h8000, 16'h7FFF, 16'hFFFF);

      for (p = 0; p < PHASES; p++) begin
         wait_for_answers();
         set_fit_mode(phase_modes[p]);
         if (p == 1) begin
            long_hold = 1'b1;
         end
         if (p == PHASES - 1) begin
            gaps_on = 1'b0;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
         end
      end

      wait_for_answers();
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
